// File: src/assert_macros.svh
// Assertion macros used by the top level of the demand queue server.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_IMPLY(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// File: src/fdqs_pkg.sv
// Shared constants, operation codes and controller/datapath link types.
package fdqs_pkg;

    localparam int MODE_W  = 2;
    localparam int ROUTE_W = 8;
    localparam int TOTAL_W = 14;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_COUNT_BITS  = 10;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SERVE  = 2'd2;

    typedef struct packed {
        logic load_op;
        logic enq;
        logic walk_start;
        logic rm_step;
        logic sv_step;
        logic ack_ld;
        logic emit_start;
        logic emit_ld;
    } fdqs_cmd_t;

    typedef struct packed {
        logic is_enq;
        logic is_rm;
        logic is_sv;
        logic units_zero;
        logic cnt_zero;
        logic rm_last;
        logic sv_more;
        logic out_free;
        logic emit_last;
    } fdqs_stat_t;

endpackage

// File: src/fifo_demand_queue_server_top.sv
// Top level of the FIFO demand queue server: controller, datapath and checks.
// The server keeps a circular queue of demand entries (route id and outstanding unit count)
// with a running total of outstanding demand that saturates at its 14-bit maximum and never
// goes below zero. An operation transfer with mode 0 appends an entry (or reports overflow
// when the queue is full), mode 1 deletes every entry of a route while keeping the order of
// the others, and mode 2 hands a batch of units to the entries from the head onwards, popping
// those that are satisfied in full and serving the head partly when the units run short.
// A serve produces one result transfer per served entry; every other case produces a single
// acknowledgment. All results of an operation carry the queue fill and total as they stand
// after the whole operation, and the final one is marked by last and carries the discarded
// units. The block handles one operation at a time. A removal walks every stored entry and a
// serve the entries that it touches, through the single read port of the queue store at one
// entry per cycle; a serve then drains the served-entry buffer at one result per cycle while
// the result side does not stall. A result waiting in the output register while the result
// side stalls holds the next operation back only once the controller needs that register
// again. The stores need no clearing pass after reset: only slots holding live entries are
// ever read.
`include "assert_macros.svh"

module fifo_demand_queue_server_top
    import fdqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             op_valid,
    output logic                             op_stall,
    input  logic [MODE_W-1:0]                mode,
    input  logic [ROUTE_W-1:0]               route_tag,
    input  logic [COUNT_BITS-1:0]            request_count,
    input  logic [COUNT_BITS-1:0]            unit_count,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [ROUTE_W-1:0]               served_route,
    output logic [COUNT_BITS-1:0]            granted_units,
    output logic                             entry_valid,
    output logic                             entry_done,
    output logic                             last,
    output logic [COUNT_BITS-1:0]            discarded_units,
    output logic [TOTAL_W-1:0]               pending_total,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_fill,
    output logic                             overflow
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    fdqs_cmd_t  cmd;
    fdqs_stat_t stat;

    // The controller only sequences; every operand and store lives in the datapath.
    fdqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fdqs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .route_tag       (route_tag),
        .request_count   (request_count),
        .unit_count      (unit_count),
        .cmd             (cmd),
        .stat            (stat),
        .res_stall       (res_stall),
        .res_valid       (res_valid),
        .served_route    (served_route),
        .granted_units   (granted_units),
        .entry_valid     (entry_valid),
        .entry_done      (entry_done),
        .last            (last),
        .discarded_units (discarded_units),
        .pending_total   (pending_total),
        .queue_fill      (queue_fill),
        .overflow        (overflow)
    );

    // The fill reported with a result never exceeds the queue depth.
    `ASSERT_IMPLY(a_fill_bound, clk, rst_n, res_valid, queue_fill <= FILL_W'(QUEUE_DEPTH))
    // An overflow is reported only by a lone acknowledgment on a full queue.
    `ASSERT_IMPLY(a_ovf_full, clk, rst_n, res_valid && overflow,
                  (queue_fill == FILL_W'(QUEUE_DEPTH)) && last && !entry_valid)
    // While an operation still owes results, no new operation transfer is taken.
    `ASSERT_IMPLY(a_hold_input, clk, rst_n, res_valid && !last, op_stall)
    // An accepted operation keeps the input side stalled in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, op_valid && !op_stall, op_stall)

endmodule

// File: src/fdqs_ctrl.sv
// Controller state machine that sequences enqueue, removal and serve operations.
module fdqs_ctrl
    import fdqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    output logic       op_stall,
    input  fdqs_stat_t stat,
    output fdqs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_REMOVE   = 3'd2;
    localparam logic [2:0] S_SERVE    = 3'd3;
    localparam logic [2:0] S_ACK      = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_LD  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.is_enq)
                begin
                    cmd.enq    = 1'b1;
                    state_next = S_ACK;
                end
                else if (stat.is_rm && !stat.cnt_zero)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_REMOVE;
                end
                else if (stat.is_sv && !stat.cnt_zero && !stat.units_zero)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_SERVE;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end
            S_REMOVE:
            begin
                cmd.rm_step = 1'b1;
                if (stat.rm_last)
                begin
                    state_next = S_ACK;
                end
            end
            S_SERVE:
            begin
                cmd.sv_step = 1'b1;
                if (!stat.sv_more)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.ack_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_start = 1'b1;
                state_next     = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign op_stall = (state_reg != S_IDLE);

endmodule

// File: src/fdqs_dpath.sv
// Datapath: queue store, running total, served-entry buffer and output register.
module fdqs_dpath
    import fdqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [MODE_W-1:0]                    mode,
    input  logic [ROUTE_W-1:0]                   route_tag,
    input  logic [COUNT_BITS-1:0]                request_count,
    input  logic [COUNT_BITS-1:0]                unit_count,
    input  fdqs_cmd_t                            cmd,
    output fdqs_stat_t                           stat,
    input  logic                                 res_stall,
    output logic                                 res_valid,
    output logic [ROUTE_W-1:0]                   served_route,
    output logic [COUNT_BITS-1:0]                granted_units,
    output logic                                 entry_valid,
    output logic                                 entry_done,
    output logic                                 last,
    output logic [COUNT_BITS-1:0]                discarded_units,
    output logic [TOTAL_W-1:0]                   pending_total,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_fill,
    output logic                                 overflow
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ROUTE_W + COUNT_BITS;
    localparam int RBUF_W  = ROUTE_W + COUNT_BITS + 1;
    localparam int SUM_W   = ((TOTAL_W > COUNT_BITS) ? TOTAL_W : COUNT_BITS) + 1;

    // Control state.
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic                  out_valid_reg;
    logic [IDX_W-1:0]      base_reg;
    logic [CNT_W-1:0]      walk_reg;
    logic [CNT_W-1:0]      kept_reg;
    logic [CNT_W-1:0]      nres_reg;
    logic [CNT_W-1:0]      emit_reg;
    logic                  ovf_reg;

    // Operation operands.
    logic [MODE_W-1:0]     op_mode_reg;
    logic [ROUTE_W-1:0]    op_route_reg;
    logic [COUNT_BITS-1:0] op_req_reg;
    logic [COUNT_BITS-1:0] units_reg;

    // Stores and their registered read data.
    logic [ENTRY_W-1:0]    queue_mem_reg [QUEUE_DEPTH];
    logic [RBUF_W-1:0]     rbuf_mem_reg  [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [RBUF_W-1:0]     rbuf_rd_reg;

    // Output register.
    logic [ROUTE_W-1:0]    out_route_reg;
    logic [COUNT_BITS-1:0] out_grant_reg;
    logic                  out_evalid_reg;
    logic                  out_done_reg;
    logic                  out_last_reg;
    logic [COUNT_BITS-1:0] out_discard_reg;
    logic [TOTAL_W-1:0]    out_total_reg;
    logic [CNT_W-1:0]      out_fill_reg;
    logic                  out_ovf_reg;

    logic [ROUTE_W-1:0]    rd_route;
    logic [COUNT_BITS-1:0] rd_rem;
    logic                  full;
    logic                  route_hit;
    logic                  fits;
    logic [COUNT_BITS-1:0] sub_val;
    logic [COUNT_BITS-1:0] grant;
    logic [COUNT_BITS-1:0] units_next;
    logic [CNT_W-1:0]      count_sv_next;
    logic [CNT_W-1:0]      kept_next;
    logic [CNT_W-1:0]      walk_inc;
    logic [CNT_W-1:0]      emit_inc;
    logic                  emit_last;
    logic [SUM_W-1:0]      tot_ext;
    logic [SUM_W-1:0]      sub_ext;
    logic [SUM_W-1:0]      add_sum;
    logic [TOTAL_W-1:0]    total_dec;
    logic [TOTAL_W-1:0]    total_inc;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    // Circular slot of an offset from a base index; the sum stays below twice the depth.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign rd_route      = rd_data_reg[ENTRY_W-1:COUNT_BITS];
    assign rd_rem        = rd_data_reg[COUNT_BITS-1:0];
    assign full          = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign route_hit     = (rd_route == op_route_reg);
    assign fits          = (rd_rem <= units_reg);
    assign grant         = fits ? rd_rem : units_reg;
    assign units_next    = fits ? (units_reg - rd_rem) : '0;
    assign count_sv_next = fits ? (count_reg - CNT_W'(1)) : count_reg;
    assign kept_next     = route_hit ? kept_reg : (kept_reg + CNT_W'(1));
    assign walk_inc      = walk_reg + CNT_W'(1);
    assign emit_inc      = emit_reg + CNT_W'(1);
    assign emit_last     = (emit_inc == nres_reg);

    // Saturating add and clamped subtract of the running total.
    always_comb
    begin
        sub_val = '0;
        if (cmd.rm_step)
        begin
            sub_val = rd_rem;
        end
        else if (cmd.sv_step)
        begin
            sub_val = grant;
        end
        tot_ext   = SUM_W'(total_reg);
        sub_ext   = SUM_W'(sub_val);
        add_sum   = tot_ext + SUM_W'(op_req_reg);
        total_dec = (sub_ext > tot_ext) ? '0 : TOTAL_W'(tot_ext - sub_ext);
        total_inc = (add_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : add_sum[TOTAL_W-1:0];
    end

    // Single write port of the queue store.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (cmd.enq && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_reg, count_reg);
            wr_data = {op_route_reg, op_req_reg};
        end
        else if (cmd.rm_step && !route_hit)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(base_reg, kept_reg);
            wr_data = rd_data_reg;
        end
        else if (cmd.sv_step && !fits)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(base_reg, walk_reg);
            wr_data = {rd_route, rd_rem - units_reg};
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // Single read port: the first entry at walk start, then one entry ahead per step.
    assign rd_en   = cmd.walk_start || cmd.rm_step || cmd.sv_step;
    assign rd_addr = cmd.walk_start ? head_reg : slot_of(base_reg, walk_inc);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= queue_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sv_step)
        begin
            rbuf_mem_reg[nres_reg[IDX_W-1:0]] <= {rd_route, grant, fits};
        end
        if (cmd.emit_start)
        begin
            rbuf_rd_reg <= rbuf_mem_reg[0];
        end
        else if (cmd.emit_ld && !emit_last)
        begin
            rbuf_rd_reg <= rbuf_mem_reg[emit_inc[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            walk_reg      <= '0;
            kept_reg      <= '0;
            nres_reg      <= '0;
            emit_reg      <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load_op)
            begin
                ovf_reg  <= 1'b0;
                nres_reg <= '0;
            end
            if (cmd.enq)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    total_reg <= total_inc;
                end
            end
            if (cmd.walk_start)
            begin
                base_reg <= head_reg;
                walk_reg <= '0;
                kept_reg <= '0;
            end
            if (cmd.rm_step)
            begin
                walk_reg <= walk_inc;
                kept_reg <= kept_next;
                if (route_hit)
                begin
                    total_reg <= total_dec;
                end
                if (stat.rm_last)
                begin
                    count_reg <= kept_next;
                end
            end
            if (cmd.sv_step)
            begin
                walk_reg  <= walk_inc;
                nres_reg  <= nres_reg + CNT_W'(1);
                total_reg <= total_dec;
                count_reg <= count_sv_next;
                if (fits)
                begin
                    head_reg <= slot_of(head_reg, CNT_W'(1));
                end
            end
            if (cmd.emit_start)
            begin
                emit_reg <= '0;
            end
            if (cmd.emit_ld)
            begin
                emit_reg <= emit_inc;
            end
            if (cmd.ack_ld || cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operands and the result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_mode_reg  <= mode;
            op_route_reg <= route_tag;
            op_req_reg   <= request_count;
            units_reg    <= (mode == MODE_SERVE) ? unit_count : '0;
        end
        else if (cmd.sv_step)
        begin
            units_reg <= units_next;
        end
        if (cmd.ack_ld)
        begin
            out_route_reg   <= '0;
            out_grant_reg   <= '0;
            out_evalid_reg  <= 1'b0;
            out_done_reg    <= 1'b0;
            out_last_reg    <= 1'b1;
            out_discard_reg <= units_reg;
            out_total_reg   <= total_reg;
            out_fill_reg    <= count_reg;
            out_ovf_reg     <= ovf_reg;
        end
        else if (cmd.emit_ld)
        begin
            out_route_reg   <= rbuf_rd_reg[RBUF_W-1:COUNT_BITS+1];
            out_grant_reg   <= rbuf_rd_reg[COUNT_BITS:1];
            out_evalid_reg  <= 1'b1;
            out_done_reg    <= rbuf_rd_reg[0];
            out_last_reg    <= emit_last;
            out_discard_reg <= emit_last ? units_reg : '0;
            out_total_reg   <= total_reg;
            out_fill_reg    <= count_reg;
            out_ovf_reg     <= ovf_reg;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.is_enq     = (op_mode_reg == MODE_ENQ);
        stat.is_rm      = (op_mode_reg == MODE_REMOVE);
        stat.is_sv      = (op_mode_reg == MODE_SERVE);
        stat.units_zero = (units_reg == '0);
        stat.cnt_zero   = (count_reg == '0);
        stat.rm_last    = (walk_inc == count_reg);
        stat.sv_more    = (units_next != '0) && (count_sv_next != '0);
        stat.out_free   = !out_valid_reg || !res_stall;
        stat.emit_last  = emit_last;
    end

    assign res_valid       = out_valid_reg;
    assign served_route    = out_route_reg;
    assign granted_units   = out_grant_reg;
    assign entry_valid     = out_evalid_reg;
    assign entry_done      = out_done_reg;
    assign last            = out_last_reg;
    assign discarded_units = out_discard_reg;
    assign pending_total   = out_total_reg;
    assign queue_fill      = out_fill_reg;
    assign overflow        = out_ovf_reg;

endmodule

// File: dv/fifo_demand_queue_server_top_test.sv
// Self-checking testbench for the FIFO demand queue server, with its own queue model.
module fifo_demand_queue_server_top_test;
    import fdqs_pkg::*;

    localparam int DEPTH  = DEF_QUEUE_DEPTH;
    localparam int CNT_W  = DEF_COUNT_BITS;
    localparam int FILL_W = $clog2(DEPTH + 1);

    // Mode 3 has no operation behind it; the block must acknowledge it and change nothing.
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    // Length of the result-side hold-off, long enough for the operation side to back up.
    localparam int HOLD_CYCLES = 250;

    // Wait after the last awaited result, so that any late stray transfer is caught.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

    // Simulation time limit for the whole run, used by the hang guard.
    localparam int RUN_LIMIT = 5_000_000;

    // One result transfer as the block should present it.
    typedef struct packed {
        logic [ROUTE_W-1:0] route;
        logic [CNT_W-1:0]   granted;
        logic               entry_valid;
        logic               entry_done;
        logic               last;
        logic [CNT_W-1:0]   discarded;
        logic [TOTAL_W-1:0] total;
        logic [FILL_W-1:0]  fill;
        logic               overflow;
    } queue_result_t;

    // Tracks the contents of the demand queue and the results that each accepted operation
    // must produce, then matches the result transfers against them in order.
    class demand_queue_tracker;
        logic [ROUTE_W-1:0] slot_route [DEPTH];
        logic [CNT_W-1:0]   slot_remaining [DEPTH];
        int                 fill;
        int                 head;
        int                 total;
        int                 errors;
        queue_result_t      awaited_results [$];

        function new();
            fill   = 0;
            head   = 0;
            total  = 0;
            errors = 0;
        endfunction

        // The running total never drops below zero.
        function void lower_total(input int amount);
            total = (amount > total) ? 0 : total - amount;
        endfunction

        function void note_operation(input logic [MODE_W-1:0]  op,
                                     input logic [ROUTE_W-1:0] route,
                                     input logic [CNT_W-1:0]   request,
                                     input logic [CNT_W-1:0]   units);
            queue_result_t      batch [$];
            queue_result_t      item;
            logic [ROUTE_W-1:0] kept_route [DEPTH];
            logic [CNT_W-1:0]   kept_remaining [DEPTH];
            int                 kept;
            int                 left;
            int                 rem;
            int                 slot;
            logic               dropped;
            dropped = 1'b0;
            left    = 0;
            case (op)
                MODE_ENQ:
                begin
                    if (fill >= DEPTH)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        slot = (head + fill) % DEPTH;
                        slot_route[slot]     = route;
                        slot_remaining[slot] = request;
                        fill++;
                        total = total + int'(request);
                        if (total > int'(TOTAL_MAX))
                        begin
                            total = int'(TOTAL_MAX);
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    kept = 0;
                    for (int i = 0; i < fill; i++)
                    begin
                        slot = (head + i) % DEPTH;
                        if (slot_route[slot] == route)
                        begin
                            lower_total(int'(slot_remaining[slot]));
                        end
                        else
                        begin
                            kept_route[kept]     = slot_route[slot];
                            kept_remaining[kept] = slot_remaining[slot];
                            kept++;
                        end
                    end
                    for (int i = 0; i < kept; i++)
                    begin
                        slot = (head + i) % DEPTH;
                        slot_route[slot]     = kept_route[i];
                        slot_remaining[slot] = kept_remaining[i];
                    end
                    fill = kept;
                end
                MODE_SERVE:
                begin
                    left = int'(units);
                    while (left > 0 && fill > 0)
                    begin
                        slot = head;
                        rem  = int'(slot_remaining[slot]);
                        item = '0;
                        item.route       = slot_route[slot];
                        item.entry_valid = 1'b1;
                        if (rem <= left)
                        begin
                            item.granted    = CNT_W'(rem);
                            item.entry_done = 1'b1;
                            left = left - rem;
                            lower_total(rem);
                            head = (head + 1) % DEPTH;
                            fill--;
                        end
                        else
                        begin
                            item.granted = CNT_W'(left);
                            slot_remaining[slot] = CNT_W'(rem - left);
                            lower_total(left);
                            left = 0;
                        end
                        batch = {batch, item};
                    end
                end
                default:
                begin
                end
            endcase
            if (batch.size() == 0)
            begin
                item = '0;
                batch = {batch, item};
            end
            foreach (batch[i])
            begin
                batch[i].total    = TOTAL_W'(total);
                batch[i].fill     = FILL_W'(fill);
                batch[i].overflow = dropped;
            end
            batch[batch.size() - 1].last      = 1'b1;
            batch[batch.size() - 1].discarded = CNT_W'(left);
            foreach (batch[i])
            begin
                awaited_results = {awaited_results, batch[i]};
            end
        endfunction

        function void compare_field(input string label, input logic [TOTAL_W-1:0] want,
                                    input logic [TOTAL_W-1:0] seen);
            if (seen !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
                errors++;
            end
        endfunction

        function void check_result(input queue_result_t seen);
            queue_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing awaited, expected none, actual %h",
                         $time, seen);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("served_route", TOTAL_W'(want.route), TOTAL_W'(seen.route));
            compare_field("granted_units", TOTAL_W'(want.granted), TOTAL_W'(seen.granted));
            compare_field("entry_valid", TOTAL_W'(want.entry_valid),
                          TOTAL_W'(seen.entry_valid));
            compare_field("entry_done", TOTAL_W'(want.entry_done), TOTAL_W'(seen.entry_done));
            compare_field("last", TOTAL_W'(want.last), TOTAL_W'(seen.last));
            compare_field("discarded_units", TOTAL_W'(want.discarded),
                          TOTAL_W'(seen.discarded));
            compare_field("pending_total", want.total, seen.total);
            compare_field("queue_fill", TOTAL_W'(want.fill), TOTAL_W'(seen.fill));
            compare_field("overflow", TOTAL_W'(want.overflow), TOTAL_W'(seen.overflow));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 op_valid;
    logic                 op_stall;
    logic [MODE_W-1:0]    mode;
    logic [ROUTE_W-1:0]   route_tag;
    logic [CNT_W-1:0]     request_count;
    logic [CNT_W-1:0]     unit_count;
    logic                 res_valid;
    logic                 res_stall;
    logic [ROUTE_W-1:0]   served_route;
    logic [CNT_W-1:0]     granted_units;
    logic                 entry_valid;
    logic                 entry_done;
    logic                 last;
    logic [CNT_W-1:0]     discarded_units;
    logic [TOTAL_W-1:0]   pending_total;
    logic [FILL_W-1:0]    queue_fill;
    logic                 overflow;

    // Set while the result side is made to hold off for a long stretch.
    logic                 hold_results;
    // Chances, in percent, that the operation side idles or the result side stalls in a cycle.
    int                   send_idle_pct;
    int                   recv_idle_pct;

    demand_queue_tracker  tracker;

    fifo_demand_queue_server_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .op_valid        (op_valid),
        .op_stall        (op_stall),
        .mode            (mode),
        .route_tag       (route_tag),
        .request_count   (request_count),
        .unit_count      (unit_count),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .served_route    (served_route),
        .granted_units   (granted_units),
        .entry_valid     (entry_valid),
        .entry_done      (entry_done),
        .last            (last),
        .discarded_units (discarded_units),
        .pending_total   (pending_total),
        .queue_fill      (queue_fill),
        .overflow        (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one operation and returns in the time step of the edge at which it is taken.
    // The caller must then either offer the next operation or lower valid in that same step,
    // otherwise the payload still on the port would be taken a second time.
    task automatic send_op(input logic [MODE_W-1:0]  op,
                           input logic [ROUTE_W-1:0] route,
                           input logic [CNT_W-1:0]   request,
                           input logic [CNT_W-1:0]   units);
        op_valid      <= 1'b1;
        mode          <= op;
        route_tag     <= route;
        request_count <= request;
        unit_count    <= units;
        @(posedge clk);
        while (op_stall)
        begin
            @(posedge clk);
        end
        tracker.note_operation(op, route, request, units);
    endtask

    // Counts are weighted towards the extremes and towards small values, so that serves
    // usually span several entries and zero-demand entries turn up regularly.
    function automatic logic [CNT_W-1:0] pick_count(input int modest);
        case ($urandom_range(9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return CNT_W'($urandom_range(1, modest));
            default:    return CNT_W'($urandom);
        endcase
    endfunction

    // Random operations. Most use a handful of recurring routes so that removals find
    // something to delete, and the mix of enqueues and serves drifts every twenty
    // operations so that the queue swings between empty and full (and overflows).
    task automatic run_random(input int count);
        logic [MODE_W-1:0]  op;
        logic [ROUTE_W-1:0] route;
        logic [CNT_W-1:0]   request;
        logic [CNT_W-1:0]   units;
        int                 pick;
        int                 enq_pct;
        enq_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 20 == 0)
            begin
                enq_pct = $urandom_range(30, 80);
            end
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                op = MODE_IGNORED;
            end
            else if (pick < 16)
            begin
                op = MODE_REMOVE;
            end
            else if (pick < 16 + enq_pct)
            begin
                op = MODE_ENQ;
            end
            else
            begin
                op = MODE_SERVE;
            end
            if ($urandom_range(3) != 0)
            begin
                route = ROUTE_W'($urandom_range(5)) * 8'h33;
            end
            else
            begin
                route = ROUTE_W'($urandom_range(255));
            end
            request = pick_count(64);
            units   = pick_count(200);
            if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                op_valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while ($urandom_range(99) < send_idle_pct);
            end
            send_op(op, route, request, units);
        end
    endtask

    // Result side: every transfer is checked against the oldest awaited result, and the
    // stall for the next cycle is chosen afresh at each edge.
    initial
    begin
        queue_result_t seen;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                seen.route       = served_route;
                seen.granted     = granted_units;
                seen.entry_valid = entry_valid;
                seen.entry_done  = entry_done;
                seen.last        = last;
                seen.discarded   = discarded_units;
                seen.total       = pending_total;
                seen.fill        = queue_fill;
                seen.overflow    = overflow;
                tracker.check_result(seen);
            end
            res_stall <= hold_results || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        tracker = new();
        rst_n         <= 1'b0;
        op_valid      <= 1'b0;
        mode          <= MODE_ENQ;
        route_tag     <= '0;
        request_count <= '0;
        unit_count    <= '0;
        hold_results  <= 1'b0;
        recv_idle_pct <= 0;
        send_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with neither side idling. First the cases that leave the empty
        // queue alone: a serve with all units to discard, a serve with none, an unknown mode.
        send_op(MODE_SERVE, 8'h00, '0, '1);
        send_op(MODE_SERVE, 8'hFF, '1, '0);
        send_op(MODE_IGNORED, 8'hFF, '1, '1);
        // A zero-demand entry at the head, then the extremes and alternating bit patterns.
        send_op(MODE_ENQ, 8'h00, '0, '0);
        send_op(MODE_ENQ, 8'hFF, '1, '1);
        send_op(MODE_ENQ, 8'hAA, 10'h155, 10'h2AA);
        send_op(MODE_ENQ, 8'h55, 10'h2AA, 10'h155);
        // A removal of a route that is not queued only acknowledges.
        send_op(MODE_REMOVE, 8'h07, '0, '0);
        // A serve with no units on a non-empty queue only acknowledges.
        send_op(MODE_SERVE, 8'h00, '0, '0);
        // One unit: the zero-demand entry is popped with nothing granted and the next entry
        // is served partly.
        send_op(MODE_SERVE, 8'h00, '0, 10'd1);
        // Fill the queue to the brim, then one more enqueue must be dropped with overflow.
        for (int i = 0; i < DEPTH - 3; i++)
        begin
            send_op(MODE_ENQ, (i % 2 == 0) ? 8'h11 : 8'hEE, (i % 3 == 0) ? '1 : 10'd40, '0);
        end
        send_op(MODE_ENQ, 8'h77, 10'd8, '0);
        // Removal of a route spread through the queue keeps the others in order.
        send_op(MODE_REMOVE, 8'h11, '0, '0);
        send_op(MODE_SERVE, 8'h00, '0, '1);

        // Operation side idles a good deal less than the result side stalls.
        send_idle_pct = 30;
        recv_idle_pct <= 69;
        run_random(150);

        // The result side holds off for a long stretch in a process of its own while
        // operations keep coming, so that the block backs up and stalls its input.
        send_idle_pct = 0;
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
        join_none
        run_random(20);

        // The other way round.
        send_idle_pct = 69;
        recv_idle_pct <= 30;
        run_random(140);

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random(135);
        op_valid <= 1'b0;

        while (tracker.awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Guards against a hang anywhere in the run.
    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/fdqs_pkg.sv
src/fdqs_ctrl.sv
src/fdqs_dpath.sv
src/fifo_demand_queue_server_top.sv
dv/fifo_demand_queue_server_top_test.sv
